FILE: rtl/core/epd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_pkg
// Shared constants and types for the escaped packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_WIDTH = 12;
  localparam int LEN_OUT_WIDTH = 12;
  localparam int OUT_DATA_WIDTH = 48;

  localparam logic [CFG_WIDTH-1:0] LENGTH_RESET = 12'h820;

  localparam logic [7:0] ESC_BYTE     = 8'hBB;
  localparam logic [7:0] FRAME_OPEN   = 8'hAA;
  localparam logic [7:0] FRAME_CLOSE  = 8'hCC;
  localparam logic [7:0] ESC_OF_ESC   = 8'h44;
  localparam logic [7:0] ESC_OF_START = 8'h55;
  localparam logic [7:0] ESC_OF_STOP  = 8'h33;

  localparam logic [2:0] EV_GOOD    = 3'd0;
  localparam logic [2:0] EV_BADSUM  = 3'd1;
  localparam logic [2:0] EV_ESCAPE  = 3'd2;
  localparam logic [2:0] EV_OVERLEN = 3'd3;
  localparam logic [2:0] EV_DOUBLE  = 3'd4;
  localparam logic [2:0] EV_FALSE   = 3'd5;
  localparam logic [2:0] EV_IDLE    = 3'd6;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_ESC   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       unesc_ok;
    logic [7:0] unesc_data;
  } entry_t;

endpackage

FILE: rtl/core/epd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_front
// Accepts raw bytes and classifies each one, including its escape decode.
// ----------------------------------------------------------------------------
module epd_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            q_full,
  output logic            q_push,
  output epd_pkg::entry_t q_entry
);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_entry.data       = s_tdata;
    q_entry.kind       = epd_pkg::KIND_DATA;
    q_entry.unesc_ok   = 1'b1;
    q_entry.unesc_data = epd_pkg::ESC_BYTE;
    unique case (s_tdata)
      epd_pkg::FRAME_OPEN:  q_entry.kind = epd_pkg::KIND_START;
      epd_pkg::FRAME_CLOSE: q_entry.kind = epd_pkg::KIND_STOP;
      epd_pkg::ESC_BYTE:    q_entry.kind = epd_pkg::KIND_ESC;
      default:              q_entry.kind = epd_pkg::KIND_DATA;
    endcase
    unique case (s_tdata)
      epd_pkg::ESC_OF_ESC:   q_entry.unesc_data = epd_pkg::ESC_BYTE;
      epd_pkg::ESC_OF_START: q_entry.unesc_data = epd_pkg::FRAME_OPEN;
      epd_pkg::ESC_OF_STOP:  q_entry.unesc_data = epd_pkg::FRAME_CLOSE;
      default:               q_entry.unesc_ok = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/epd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_queue
// Short register queue between the classifier and the deframer.
// ----------------------------------------------------------------------------
module epd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  epd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output epd_pkg::entry_t head
);

  localparam int Depth = epd_pkg::QUEUE_DEPTH;
  localparam int PtrWidth = $clog2(Depth);

  epd_pkg::entry_t           mem [Depth];
  logic [PtrWidth-1:0]       wr_ptr;
  logic [PtrWidth-1:0]       rd_ptr;
  logic [PtrWidth:0]         fill;

  assign full  = (fill == (PtrWidth + 1)'(Depth));
  assign valid = (fill != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/epd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_back
// Packet state, checksum and length tracking, and the event output register.
// ----------------------------------------------------------------------------
module epd_back #(
  parameter int LENGTH_WIDTH = epd_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [epd_pkg::CFG_WIDTH-1:0]   max_packet_length,
  input  logic                            q_valid,
  input  epd_pkg::entry_t                 q_head,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [epd_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);

  localparam int LW = LENGTH_WIDTH;
  localparam int CW = epd_pkg::CFG_WIDTH;
  localparam int XW = LW + CW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DATA   = 3'b010,
    ST_ESCAPE = 3'b100
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [LW-1:0]  count;
  logic [LW-1:0]  count_next;
  logic [7:0]     sum;
  logic [7:0]     sum_next;
  logic [7:0]     last_byte;
  logic [7:0]     last_byte_next;
  logic [7:0]     type_high;
  logic [7:0]     type_high_next;
  logic [7:0]     type_low;
  logic [7:0]     type_low_next;

  logic           emit;
  logic [2:0]     ev_code;
  logic [epd_pkg::LEN_OUT_WIDTH-1:0] ev_len;
  logic [15:0]    ev_type;
  logic [7:0]     ev_rx;
  logic [7:0]     ev_calc;

  logic [XW-1:0]  count_ext;
  logic [XW-1:0]  max_ext;
  logic [XW-1:0]  limit_ext;
  logic           at_limit;
  logic           do_store;
  logic [7:0]     store_byte;
  logic [7:0]     calc;

  localparam logic [XW-1:0] CountMax = {{CW{1'b0}}, {LW{1'b1}}};

  assign count_ext = {{CW{1'b0}}, count};
  assign max_ext   = {{LW{1'b0}}, max_packet_length};
  assign limit_ext = (max_ext > CountMax) ? CountMax : max_ext;
  assign at_limit  = (count_ext >= limit_ext);
  assign calc      = sum - last_byte;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    state_next     = state;
    count_next     = count;
    sum_next       = sum;
    last_byte_next = last_byte;
    type_high_next = type_high;
    type_low_next  = type_low;
    emit           = 1'b0;
    ev_code        = epd_pkg::EV_GOOD;
    ev_len         = count_ext[epd_pkg::LEN_OUT_WIDTH-1:0];
    ev_type        = '0;
    ev_rx          = '0;
    ev_calc        = '0;
    do_store       = 1'b0;
    store_byte     = q_head.data;

    if (q_head.kind == epd_pkg::KIND_START) begin
      state_next = ST_DATA;
      count_next = '0;
      sum_next   = '0;
      if (state != ST_IDLE) begin
        emit = 1'b1;
        if (count == '0) begin
          ev_code = epd_pkg::EV_DOUBLE;
        end else begin
          ev_code = epd_pkg::EV_FALSE;
        end
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          emit    = 1'b1;
          ev_code = epd_pkg::EV_IDLE;
          ev_len  = '0;
        end
        ST_ESCAPE: begin
          if (!q_head.unesc_ok) begin
            emit       = 1'b1;
            ev_code    = epd_pkg::EV_ESCAPE;
            state_next = ST_IDLE;
            count_next = '0;
            sum_next   = '0;
          end else begin
            do_store   = 1'b1;
            store_byte = q_head.unesc_data;
          end
        end
        ST_DATA: begin
          if (q_head.kind == epd_pkg::KIND_ESC) begin
            state_next = ST_ESCAPE;
          end else if (q_head.kind == epd_pkg::KIND_STOP) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
            count_next = '0;
            sum_next   = '0;
            if (count == '0) begin
              ev_code = epd_pkg::EV_BADSUM;
            end else begin
              ev_rx   = last_byte;
              ev_calc = calc;
              ev_code = (calc == last_byte) ? epd_pkg::EV_GOOD : epd_pkg::EV_BADSUM;
              if (count_ext >= XW'(3)) begin
                ev_type = {type_high, type_low};
              end
            end
          end else begin
            do_store = 1'b1;
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end

    if (do_store) begin
      if (at_limit) begin
        emit       = 1'b1;
        ev_code    = epd_pkg::EV_OVERLEN;
        state_next = ST_IDLE;
        count_next = '0;
        sum_next   = '0;
      end else begin
        state_next     = ST_DATA;
        sum_next       = sum + store_byte;
        last_byte_next = store_byte;
        if (count_ext == XW'(1)) begin
          type_high_next = store_byte;
        end else if (count_ext == XW'(2)) begin
          type_low_next = store_byte;
        end
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      sum       <= '0;
      last_byte <= '0;
      type_high <= '0;
      type_low  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        state     <= state_next;
        count     <= count_next;
        sum       <= sum_next;
        last_byte <= last_byte_next;
        type_high <= type_high_next;
        type_low  <= type_low_next;
        m_tvalid  <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      m_tdata <= {1'b0, ev_calc, ev_rx, ev_type, ev_len, ev_code};
    end
  end

endmodule

FILE: rtl/core/escaped_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_packet_deframer
// Byte-stuffed packet deframer with an 8-bit additive checksum and events.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   rx_byte, one raw byte per transfer
//  m_axis    out  one event per transfer
//  cfg       in   max_packet_length write
//
// A byte is written into the queue, and its event is registered in the back part.
// One byte per cycle is sustained while m_axis does not stall; the per-byte
// state update in the back part is the single loop that sets that figure.
// The four-entry queue lets the input keep taking bytes while an event waits.
// Reset is synchronous and restores the length limit to 2080.
module escaped_packet_deframer #(
  parameter int LENGTH_WIDTH = epd_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // rx_byte[7:0]
  input  logic [7:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // event_code[2:0], packet_length[14:3], packet_type[30:15],
  // received_checksum[38:31], computed_checksum[46:39], zero pad[47]
  output logic [epd_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input  logic        cfg_we,
  input  logic [epd_pkg::CFG_WIDTH-1:0] cfg_data
);

  logic [epd_pkg::CFG_WIDTH-1:0] max_packet_length;
  logic                          q_push;
  logic                          q_full;
  logic                          q_pop;
  logic                          q_valid;
  epd_pkg::entry_t               q_entry;
  epd_pkg::entry_t               q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_length <= epd_pkg::LENGTH_RESET;
    end else if (cfg_we) begin
      max_packet_length <= cfg_data;
    end
  end

  epd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  epd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  epd_back #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .max_packet_length (max_packet_length),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata)
  );

endmodule

FILE: rtl/core/epd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks on the event stream of the deframer.
// ----------------------------------------------------------------------------
module epd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  logic [2:0] code;
  assign code = m_tdata[2:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled event changed or vanished.");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> code <= epd_pkg::EV_IDLE)
    else $error("Undefined event code.");

  a_nolen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (code == epd_pkg::EV_DOUBLE || code == epd_pkg::EV_IDLE)
    |-> m_tdata[14:3] == 12'd0)
    else $error("Double start or idle drop carries a length.");

  a_nosum: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && code != epd_pkg::EV_GOOD && code != epd_pkg::EV_BADSUM
    |-> m_tdata[47:15] == 33'd0)
    else $error("Discard event carries type or checksums.");

endmodule

bind escaped_packet_deframer epd_checker u_epd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/deframer_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_event_checker
// Watches the byte, event and configuration channels of the deframer. It
// keeps its own copy of the framing state, predicts the event that each
// accepted byte causes, and compares every event transfer field by field.
// ----------------------------------------------------------------------------
module deframer_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [epd_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input  logic        cfg_we,
  input  logic [epd_pkg::CFG_WIDTH-1:0] cfg_data,
  output int          fail_count,
  output int          expected_count
);

  typedef struct packed {
    logic [2:0]  code;
    logic [11:0] pkt_len;
    logic [15:0] ptype;
    logic [7:0]  rx_sum;
    logic [7:0]  calc_sum;
  } deframe_event_t;

  deframe_event_t pending_events[$];
  deframe_event_t want_ev;
  deframe_event_t got_ev;

  logic [11:0] length_limit;
  logic        open_pkt;
  logic        esc_wait;
  logic [7:0]  sum_acc;
  logic [7:0]  last_byte;
  logic [11:0] byte_count;
  logic [7:0]  type_hi;
  logic [7:0]  type_lo;

  function automatic deframe_event_t make_event(input logic [2:0] code,
                                                input logic [11:0] pkt_len,
                                                input logic [15:0] ptype,
                                                input logic [7:0] rx_sum,
                                                input logic [7:0] calc_sum);
    deframe_event_t ev;
    ev.code = code;
    ev.pkt_len = pkt_len;
    ev.ptype = ptype;
    ev.rx_sum = rx_sum;
    ev.calc_sum = calc_sum;
    return ev;
  endfunction

  task automatic clear_frame();
    sum_acc = 8'd0;
    byte_count = 12'd0;
    esc_wait = 1'b0;
  endtask

  task automatic store_payload(input logic [7:0] b, output logic kept);
    if (byte_count >= length_limit) begin
      open_pkt = 1'b0;
      clear_frame();
      kept = 1'b0;
    end else begin
      sum_acc = sum_acc + b;
      last_byte = b;
      if (byte_count == 12'd1) type_hi = b;
      else if (byte_count == 12'd2) type_lo = b;
      byte_count = byte_count + 12'd1;
      kept = 1'b1;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [11:0] held;
    logic        kept;
    logic        good_esc;
    logic [7:0]  v;
    logic [7:0]  calc;
    logic [15:0] ptype;
    held = byte_count;
    v = 8'd0;
    if (b == epd_pkg::FRAME_OPEN) begin
      if (open_pkt) begin
        if (held == 12'd0) begin
          pending_events.push_back(make_event(epd_pkg::EV_DOUBLE, '0, '0, '0, '0));
        end else begin
          pending_events.push_back(make_event(epd_pkg::EV_FALSE, held, '0, '0, '0));
        end
      end
      open_pkt = 1'b1;
      clear_frame();
    end else if (!open_pkt) begin
      pending_events.push_back(make_event(epd_pkg::EV_IDLE, '0, '0, '0, '0));
    end else if (esc_wait) begin
      esc_wait = 1'b0;
      good_esc = 1'b1;
      case (b)
        epd_pkg::ESC_OF_ESC:   v = epd_pkg::ESC_BYTE;
        epd_pkg::ESC_OF_START: v = epd_pkg::FRAME_OPEN;
        epd_pkg::ESC_OF_STOP:  v = epd_pkg::FRAME_CLOSE;
        default:               good_esc = 1'b0;
      endcase
      if (!good_esc) begin
        open_pkt = 1'b0;
        clear_frame();
        pending_events.push_back(make_event(epd_pkg::EV_ESCAPE, held, '0, '0, '0));
      end else begin
        store_payload(v, kept);
        if (!kept) begin
          pending_events.push_back(make_event(epd_pkg::EV_OVERLEN, held, '0, '0, '0));
        end
      end
    end else if (b == epd_pkg::ESC_BYTE) begin
      esc_wait = 1'b1;
    end else if (b == epd_pkg::FRAME_CLOSE) begin
      open_pkt = 1'b0;
      if (held == 12'd0) begin
        pending_events.push_back(make_event(epd_pkg::EV_BADSUM, '0, '0, '0, '0));
      end else begin
        calc = sum_acc - last_byte;
        ptype = (held >= 12'd3) ? {type_hi, type_lo} : 16'd0;
        pending_events.push_back(make_event(
            (calc == last_byte) ? epd_pkg::EV_GOOD : epd_pkg::EV_BADSUM,
            held, ptype, last_byte, calc));
      end
      clear_frame();
    end else begin
      store_payload(b, kept);
      if (!kept) begin
        pending_events.push_back(make_event(epd_pkg::EV_OVERLEN, held, '0, '0, '0));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      length_limit = epd_pkg::LENGTH_RESET;
      open_pkt = 1'b0;
      last_byte = 8'd0;
      type_hi = 8'd0;
      type_lo = 8'd0;
      clear_frame();
      pending_events.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_events.size() == 0) begin
          $error("Unexpected event transfer: %h", m_tdata);
          fail_count++;
        end else begin
          want_ev = pending_events.pop_front();
          got_ev.code = m_tdata[2:0];
          got_ev.pkt_len = m_tdata[14:3];
          got_ev.ptype = m_tdata[30:15];
          got_ev.rx_sum = m_tdata[38:31];
          got_ev.calc_sum = m_tdata[46:39];
          check_field("event_code", 16'(want_ev.code), 16'(got_ev.code));
          check_field("packet_length", 16'(want_ev.pkt_len), 16'(got_ev.pkt_len));
          check_field("packet_type", want_ev.ptype, got_ev.ptype);
          check_field("received_checksum", 16'(want_ev.rx_sum), 16'(got_ev.rx_sum));
          check_field("computed_checksum", 16'(want_ev.calc_sum),
                      16'(got_ev.calc_sum));
        end
      end
      if (cfg_we) length_limit = cfg_data;
      if (s_tvalid && s_tready) predict_byte(s_tdata);
    end
    expected_count = pending_events.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte streams into the deframer under several length limits,
// with random gaps on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET = 1950;
  localparam int PHASES = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [epd_pkg::OUT_DATA_WIDTH-1:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [epd_pkg::CFG_WIDTH-1:0] cfg_data = '0;

  int fail_count;
  int expected_count;
  int tx_idle_pct = 18;
  int rx_idle_pct = 18;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  escaped_packet_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  deframer_event_checker event_monitor (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .expected_count (expected_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_raw(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [epd_pkg::CFG_WIDTH-1:0] value);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(5))
        0: return epd_pkg::FRAME_OPEN;
        1: return epd_pkg::FRAME_CLOSE;
        2: return epd_pkg::ESC_BYTE;
        3: return epd_pkg::ESC_OF_ESC;
        4: return epd_pkg::ESC_OF_START;
        default: return epd_pkg::ESC_OF_STOP;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame(input int frame_max);
    logic [7:0] body[$];
    logic [7:0] chk;
    int n;
    int shape;
    int r;
    shape = $urandom_range(99);
    if (shape < 12) begin
      repeat ($urandom_range(1, 4)) send_raw(pick_byte());
    end else begin
      n = $urandom_range(0, frame_max);
      chk = 8'd0;
      for (int i = 0; i < n; i++) begin
        body.push_back(pick_byte());
        chk = chk + body[i];
      end
      r = $urandom_range(99);
      if (r < 80) body.push_back(chk);
      else if (r < 95) body.push_back(8'($urandom_range(255)));
      send_raw(epd_pkg::FRAME_OPEN);
      if (shape < 17) send_raw(epd_pkg::FRAME_OPEN);
      foreach (body[i]) begin
        if (body[i] == epd_pkg::FRAME_OPEN) begin
          send_raw(epd_pkg::ESC_BYTE);
          send_raw(epd_pkg::ESC_OF_START);
        end else if (body[i] == epd_pkg::ESC_BYTE) begin
          send_raw(epd_pkg::ESC_BYTE);
          send_raw(epd_pkg::ESC_OF_ESC);
        end else if (body[i] == epd_pkg::FRAME_CLOSE) begin
          send_raw(epd_pkg::ESC_BYTE);
          send_raw(epd_pkg::ESC_OF_STOP);
        end else begin
          send_raw(body[i]);
        end
      end
      if (shape < 24) begin
        send_raw(epd_pkg::ESC_BYTE);
        send_raw(pick_byte());
      end
      if (shape < 24 || shape >= 30) send_raw(epd_pkg::FRAME_CLOSE);
    end
  endtask

  initial begin
    logic [7:0] reset_run [0:28];
    logic [7:0] limit_run [0:3];
    logic [epd_pkg::CFG_WIDTH-1:0] limits [0:PHASES-1];
    int frame_max;

    reset_run = '{8'h00, 8'hFF, epd_pkg::FRAME_OPEN, epd_pkg::FRAME_CLOSE,
                  epd_pkg::FRAME_OPEN, epd_pkg::FRAME_OPEN, 8'h01,
                  epd_pkg::FRAME_OPEN, 8'h12, 8'h34, 8'h56, 8'h9C, epd_pkg::FRAME_CLOSE,
                  epd_pkg::FRAME_OPEN, epd_pkg::ESC_BYTE, epd_pkg::ESC_OF_ESC,
                  epd_pkg::ESC_BYTE, epd_pkg::ESC_OF_START,
                  epd_pkg::ESC_BYTE, epd_pkg::ESC_OF_STOP, 8'h31, epd_pkg::FRAME_CLOSE,
                  epd_pkg::FRAME_OPEN, epd_pkg::ESC_BYTE, 8'h00,
                  epd_pkg::FRAME_OPEN, 8'h05, 8'h06, epd_pkg::FRAME_CLOSE};
    limit_run = '{epd_pkg::FRAME_OPEN, 8'h01, epd_pkg::ESC_BYTE, epd_pkg::ESC_OF_ESC};
    limits = '{12'hFFF, 12'd0, 12'd1, 12'd9, epd_pkg::LENGTH_RESET,
               12'($urandom_range(3, 40))};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (reset_run[i]) send_raw(reset_run[i]);
    write_limit(12'd1);
    foreach (limit_run[i]) send_raw(limit_run[i]);

    for (int p = 0; p < PHASES; p++) begin
      write_limit(limits[p]);
      tx_idle_pct = (p == 3) ? 0 : 18;
      rx_idle_pct = (p == 3) ? 0 : 18;
      frame_max = (limits[p] <= 30) ? limits[p] + 2 : 12;
      while (bytes_sent < (p + 1) * ITEM_TARGET / PHASES) send_frame(frame_max);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/epd_pkg.sv
rtl/core/epd_front.sv
rtl/core/epd_queue.sv
rtl/core/epd_back.sv
rtl/core/escaped_packet_deframer.sv
rtl/core/epd_checker.sv
tb/deframer_event_checker.sv
tb/testbench.sv
